FILE: rtl/core/bqs_pkg.sv
package bqs_pkg;

  // fixed-point scaling of the coefficients and of the delay terms
  localparam int unsigned COEF_FRAC_BITS = 30;
  localparam int unsigned FB_SHIFT       = 32 - COEF_FRAC_BITS;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  // largest high product that still fits after the left shift
  localparam logic signed [ACC_W-1:0] FB_LIM  = ACC_MAX >>> FB_SHIFT;
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
      ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

  localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_B0       = 3'd0,
    CFG_COEF_B1       = 3'd1,
    CFG_COEF_B2       = 3'd2,
    CFG_COEF_A1       = 3'd3,
    CFG_COEF_A2       = 3'd4,
    CFG_CHANNEL_MODE  = 3'd5,
    CFG_SAMPLE_FORMAT = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FMT_U8   = 2'd0,
    FMT_S16  = 2'd1,
    FMT_S32  = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic                     stereo;
    fmt_e                     fmt;
  } cfg_t;

  typedef enum logic [2:0] {
    COEF_SEL_B0,
    COEF_SEL_B1,
    COEF_SEL_B2,
    COEF_SEL_A1,
    COEF_SEL_A2
  } coef_sel_e;

  typedef enum logic [1:0] {
    OPD_X,
    OPD_YHI,
    OPD_YLO
  } opd_sel_e;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_Y_LOAD,
    ALU_ACC_P,
    ALU_FB_HI,
    ALU_FB_LO,
    ALU_ACC_SUB,
    ALU_D1_WR,
    ALU_D2_WR
  } alu_op_e;

  typedef enum logic {
    JMP_NONE,
    JMP_BYPASS
  } jmp_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    logic              mul_en;
    coef_sel_e         coef_sel;
    opd_sel_e          opd_sel;
    alu_op_e           alu_op;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
    logic              done;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_BYPASS = 4'd10;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

FILE: rtl/core/biquad_filter_stereo_core.sv
// stereo biquad, transposed direct form ii, fixed point: y = b0*x + d1,
// d1 <= b1*x - a1*y + d2, d2 <= b2*x - a2*y, with q2.30 coefficients and
// q34.30 delay terms (two per channel, cleared by reset). every internal add,
// subtract and feedback product saturates to 64 bits; the output is y
// truncated toward zero and clamped to the sample format, clipped flags the
// clamp. mono mode ignores channel_i and always uses channel 0 state.
// format code 3 passes the sample through unchanged with no state update.
// each item runs a small microcode program of 10 steps, which drives a single
// shared 32x33 multiplier and a 64-bit saturating alu, at most one product
// per step; format 3 jumps from the first step to a bypass step. a new
// request is taken once the program returns to idle. the result sits in an
// output register, so the next request is accepted while it waits; the final
// step only holds if the previous result has not been taken yet.
// configuration registers (index: 0 b0, 1 b1, 2 b2, 3 a1, 4 a2,
// 5 channel_mode, 6 sample_format) are written with cfg_we_i and should only
// change while the block is idle.
module biquad_filter_stereo_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input requests
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [bqs_pkg::SAMPLE_W-1:0]    sample_in_i,
  input  logic                                   channel_i,
  // result requests
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [bqs_pkg::SAMPLE_W-1:0]    sample_out_o,
  output logic                                   clipped_o,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [bqs_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [bqs_pkg::COEF_W-1:0]             cfg_data_i
);

  bqs_pkg::cfg_t  cfg_q;
  bqs_pkg::ctrl_t ctrl;

  logic [bqs_pkg::STEP_W-1:0] step;
  logic idle, fire, done, accept;

  logic signed [bqs_pkg::SAMPLE_W-1:0] res_sample;
  logic                                res_clip;

  logic                                out_valid_q;
  logic signed [bqs_pkg::SAMPLE_W-1:0] sample_out_q;
  logic                                clipped_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0     <= bqs_pkg::B0_RESET;
      cfg_q.b1     <= '0;
      cfg_q.b2     <= '0;
      cfg_q.a1     <= '0;
      cfg_q.a2     <= '0;
      cfg_q.stereo <= 1'b0;
      cfg_q.fmt    <= bqs_pkg::FMT_S16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bqs_pkg::CFG_COEF_B0:       cfg_q.b0     <= cfg_data_i;
        bqs_pkg::CFG_COEF_B1:       cfg_q.b1     <= cfg_data_i;
        bqs_pkg::CFG_COEF_B2:       cfg_q.b2     <= cfg_data_i;
        bqs_pkg::CFG_COEF_A1:       cfg_q.a1     <= cfg_data_i;
        bqs_pkg::CFG_COEF_A2:       cfg_q.a2     <= cfg_data_i;
        bqs_pkg::CFG_CHANNEL_MODE:  cfg_q.stereo <= cfg_data_i[0];
        bqs_pkg::CFG_SAMPLE_FORMAT: cfg_q.fmt    <= bqs_pkg::fmt_e'(cfg_data_i[1:0]);
        default: ;  // unmapped index is ignored
      endcase
    end
  end

  // a request starts the program only from idle
  assign in_ready_o = idle;
  assign accept     = in_valid_i & idle;

  bqs_ucode_rom u_rom (
    .step_i (step),
    .ctrl_o (ctrl)
  );

  bqs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .bypass_i    (cfg_q.fmt == bqs_pkg::FMT_RSVD),
    .out_block_i (out_valid_q & ~out_ready_i),
    .ctrl_i      (ctrl),
    .step_o      (step),
    .idle_o      (idle),
    .fire_o      (fire),
    .done_o      (done)
  );

  bqs_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .load_i       (accept),
    .sample_i     (sample_in_i),
    .channel_i    (channel_i),
    .fire_i       (fire),
    .ctrl_i       (ctrl),
    .res_sample_o (res_sample),
    .res_clip_o   (res_clip)
  );

  // output register, freed when the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      sample_out_q <= res_sample;
      clipped_q    <= res_clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule

FILE: rtl/core/bqs_ucode_rom.sv
module bqs_ucode_rom (
  input  logic [bqs_pkg::STEP_W-1:0] step_i,
  output bqs_pkg::ctrl_t             ctrl_o
);

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.coef_sel = bqs_pkg::COEF_SEL_B0;
    ctrl_o.opd_sel  = bqs_pkg::OPD_X;
    ctrl_o.alu_op   = bqs_pkg::ALU_NOP;
    ctrl_o.jmp      = bqs_pkg::JMP_NONE;
    case (step_i)
      4'd0: begin
        // b0*x, reserved format skips the filter
        ctrl_o.mul_en = 1'b1;
        ctrl_o.jmp    = bqs_pkg::JMP_BYPASS;
        ctrl_o.target = bqs_pkg::STEP_BYPASS;
      end
      4'd1: begin
        ctrl_o.alu_op   = bqs_pkg::ALU_Y_LOAD;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.coef_sel = bqs_pkg::COEF_SEL_B1;
      end
      4'd2: begin
        ctrl_o.alu_op   = bqs_pkg::ALU_ACC_P;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.coef_sel = bqs_pkg::COEF_SEL_A1;
        ctrl_o.opd_sel  = bqs_pkg::OPD_YHI;
      end
      4'd3: begin
        ctrl_o.alu_op   = bqs_pkg::ALU_FB_HI;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.coef_sel = bqs_pkg::COEF_SEL_A1;
        ctrl_o.opd_sel  = bqs_pkg::OPD_YLO;
      end
      4'd4: begin
        ctrl_o.alu_op   = bqs_pkg::ALU_FB_LO;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.coef_sel = bqs_pkg::COEF_SEL_B2;
      end
      4'd5: begin
        ctrl_o.alu_op = bqs_pkg::ALU_ACC_SUB;
      end
      4'd6: begin
        ctrl_o.alu_op   = bqs_pkg::ALU_D1_WR;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.coef_sel = bqs_pkg::COEF_SEL_A2;
        ctrl_o.opd_sel  = bqs_pkg::OPD_YHI;
      end
      4'd7: begin
        ctrl_o.alu_op   = bqs_pkg::ALU_FB_HI;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.coef_sel = bqs_pkg::COEF_SEL_A2;
        ctrl_o.opd_sel  = bqs_pkg::OPD_YLO;
      end
      4'd8: begin
        ctrl_o.alu_op = bqs_pkg::ALU_FB_LO;
      end
      4'd9: begin
        ctrl_o.alu_op = bqs_pkg::ALU_D2_WR;
        ctrl_o.done   = 1'b1;
      end
      default: begin
        // bypass step and unused codes just finish
        ctrl_o.done = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/core/bqs_seq.sv
module bqs_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       bypass_i,
  input  logic                       out_block_i,
  input  bqs_pkg::ctrl_t             ctrl_i,
  output logic [bqs_pkg::STEP_W-1:0] step_o,
  output logic                       idle_o,
  output logic                       fire_o,
  output logic                       done_o
);

  bqs_pkg::seq_state_e state_q, state_d;
  logic [bqs_pkg::STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqs_pkg::SEQ_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    fire_o  = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      bqs_pkg::SEQ_IDLE: begin
        if (start_i) begin
          state_d = bqs_pkg::SEQ_RUN;
          step_d  = '0;
        end
      end
      bqs_pkg::SEQ_RUN: begin
        // last step waits while the previous result is still held
        fire_o = !(ctrl_i.done && out_block_i);
        if (fire_o) begin
          if (ctrl_i.done) begin
            done_o  = 1'b1;
            state_d = bqs_pkg::SEQ_IDLE;
            step_d  = '0;
          end else if (ctrl_i.jmp == bqs_pkg::JMP_BYPASS && bypass_i) begin
            step_d = ctrl_i.target;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = bqs_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign step_o = step_q;
  assign idle_o = (state_q == bqs_pkg::SEQ_IDLE);

endmodule

FILE: rtl/core/bqs_datapath.sv
module bqs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqs_pkg::cfg_t                       cfg_i,
  input  logic                                load_i,
  input  logic signed [bqs_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                channel_i,
  input  logic                                fire_i,
  input  bqs_pkg::ctrl_t                      ctrl_i,
  output logic signed [bqs_pkg::SAMPLE_W-1:0] res_sample_o,
  output logic                                res_clip_o
);

  localparam int unsigned AW = bqs_pkg::ACC_W;

  logic signed [bqs_pkg::SAMPLE_W-1:0] raw_q;
  logic                                ch_q;
  logic signed [AW-1:0] p_q, y_q, acc_q, fb_q;
  logic                 fbsat_q;
  logic signed [AW-1:0] d1_q [2];
  logic signed [AW-1:0] d2_q [2];

  logic signed [bqs_pkg::SAMPLE_W-1:0] x;
  logic signed [bqs_pkg::COEF_W-1:0]   mul_a;
  logic signed [32:0]                  mul_b;
  logic signed [AW:0]                  prod;
  logic signed [AW-1:0]                q;

  // sample in its format
  always_comb begin
    case (cfg_i.fmt)
      bqs_pkg::FMT_U8:  x = {24'd0, raw_q[7:0]};
      bqs_pkg::FMT_S16: x = {{16{raw_q[15]}}, raw_q[15:0]};
      default:          x = raw_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.coef_sel)
      bqs_pkg::COEF_SEL_B0: mul_a = cfg_i.b0;
      bqs_pkg::COEF_SEL_B1: mul_a = cfg_i.b1;
      bqs_pkg::COEF_SEL_B2: mul_a = cfg_i.b2;
      bqs_pkg::COEF_SEL_A1: mul_a = cfg_i.a1;
      bqs_pkg::COEF_SEL_A2: mul_a = cfg_i.a2;
      default:              mul_a = cfg_i.b0;
    endcase
    case (ctrl_i.opd_sel)
      bqs_pkg::OPD_YHI: mul_b = {y_q[AW-1], y_q[AW-1:32]};
      bqs_pkg::OPD_YLO: mul_b = {1'b0, y_q[31:0]};
      default:          mul_b = {x[bqs_pkg::SAMPLE_W-1], x};
    endcase
  end

  // all products fit in 64 bits
  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      raw_q <= sample_i;
      ch_q  <= cfg_i.stereo & channel_i;
    end
    if (fire_i && ctrl_i.mul_en) begin
      p_q <= prod[AW-1:0];
    end
    if (fire_i) begin
      case (ctrl_i.alu_op)
        bqs_pkg::ALU_Y_LOAD:  y_q <= bqs_pkg::sat_add(p_q, d1_q[ch_q]);
        bqs_pkg::ALU_ACC_P:   acc_q <= p_q;
        bqs_pkg::ALU_FB_HI: begin
          if (p_q > bqs_pkg::FB_LIM) begin
            fb_q    <= bqs_pkg::ACC_MAX;
            fbsat_q <= 1'b1;
          end else if (p_q < ~bqs_pkg::FB_LIM) begin
            fb_q    <= bqs_pkg::ACC_MIN;
            fbsat_q <= 1'b1;
          end else begin
            fb_q    <= p_q <<< bqs_pkg::FB_SHIFT;
            fbsat_q <= 1'b0;
          end
        end
        bqs_pkg::ALU_FB_LO: begin
          if (!fbsat_q) begin
            fb_q <= bqs_pkg::sat_add(fb_q, p_q >>> bqs_pkg::COEF_FRAC_BITS);
          end
        end
        bqs_pkg::ALU_ACC_SUB: acc_q <= bqs_pkg::sat_sub(acc_q, fb_q);
        // d1 takes the accumulator, which then picks up b2*x
        bqs_pkg::ALU_D1_WR:   acc_q <= p_q;
        default: ;
      endcase
    end
  end

  // delay terms, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q[0] <= '0;
      d1_q[1] <= '0;
      d2_q[0] <= '0;
      d2_q[1] <= '0;
    end else if (fire_i) begin
      if (ctrl_i.alu_op == bqs_pkg::ALU_D1_WR) begin
        d1_q[ch_q] <= bqs_pkg::sat_add(acc_q, d2_q[ch_q]);
      end
      if (ctrl_i.alu_op == bqs_pkg::ALU_D2_WR) begin
        d2_q[ch_q] <= bqs_pkg::sat_sub(acc_q, fb_q);
      end
    end
  end

  // truncate toward zero, then clamp to the format range
  assign q = (y_q[AW-1] ? (y_q + bqs_pkg::TRUNC_BIAS) : y_q) >>> bqs_pkg::COEF_FRAC_BITS;

  always_comb begin
    res_sample_o = q[bqs_pkg::SAMPLE_W-1:0];
    res_clip_o   = 1'b0;
    case (cfg_i.fmt)
      bqs_pkg::FMT_U8: begin
        if (q > 64'sd255) begin
          res_sample_o = 32'sd255;
          res_clip_o   = 1'b1;
        end else if (q < 64'sd0) begin
          res_sample_o = 32'sd0;
          res_clip_o   = 1'b1;
        end
      end
      bqs_pkg::FMT_S16: begin
        if (q > 64'sd32767) begin
          res_sample_o = 32'sd32767;
          res_clip_o   = 1'b1;
        end else if (q < -64'sd32768) begin
          res_sample_o = -32'sd32768;
          res_clip_o   = 1'b1;
        end
      end
      bqs_pkg::FMT_S32: begin
        if (q > 64'sd2147483647) begin
          res_sample_o = 32'sh7FFF_FFFF;
          res_clip_o   = 1'b1;
        end else if (q < -64'sd2147483648) begin
          res_sample_o = 32'sh8000_0000;
          res_clip_o   = 1'b1;
        end
      end
      default: begin
        res_sample_o = raw_q;
      end
    endcase
  end

endmodule
